### sv/ppbs_pkg.sv
// Shared package for the particle pool block: sizes, entry layout, FSM states,
// constant sine and drag tables, and fixed-point helper functions.
// No dependencies; the top level takes names from here.
`default_nettype none

package ppbs_pkg;

  // Pool and table sizes
  localparam int POOL_DEPTH       = 64;
  localparam int ANGLE_TABLE_BITS = 10;
  localparam int DAMP_TABLE_BITS  = 8;

  localparam int ADDR_W = (POOL_DEPTH > 1) ? $clog2(POOL_DEPTH) : 1;
  localparam int CNT_W  = $clog2(POOL_DEPTH + 1);
  localparam int QTR    = 1 << (ANGLE_TABLE_BITS - 2);
  localparam int DAMP_N = 1 << DAMP_TABLE_BITS;

  // Item kinds and register indexes
  localparam logic KIND_TICK = 1'b1;
  localparam int CFG_IDX_W = 2;
  localparam logic [CFG_IDX_W-1:0] REG_GRAVITY = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_FLOOR   = 2'd1;

  // Reset values of the registers
  localparam logic [22:0]        GRAVITY_RESET = 23'd153600;
  localparam logic signed [23:0] FLOOR_RESET   = 24'sd512;

  // Spawn draw scaling
  localparam logic [24:0] VZ_MIN_F   = 25'd5033165;
  localparam logic [23:0] VZ_SPAN    = 24'd15099494;
  localparam logic [24:0] SIZE_MIN_G = 25'd10066330;
  localparam logic [23:0] SIZE_SPAN  = 24'd13421773;
  localparam logic [15:0] LIFE_BASE  = 16'd16384;
  localparam logic [24:0] SPEED_ONE  = 25'd8388608;
  localparam int GEN_DRAWS = 5;

  // Divide by five, one byte per step: floor(v / 5) = (v * RECIP5) >> 14 for v < 1280
  localparam logic [11:0] RECIP5    = 12'd3277;
  localparam logic [2:0]  DIV_FIVE  = 3'd5;
  localparam int          DIV_BYTES = 7;

  localparam logic [63:0] HALF_PI_Q30 = 64'd1686629713;

  // One pool entry as stored in the RAM
  typedef struct packed {
    logic signed [23:0] x;
    logic signed [23:0] y;
    logic signed [23:0] z;
    logic signed [23:0] vx;
    logic signed [23:0] vy;
    logic signed [23:0] vz;
    logic [15:0]        life;
    logic [15:0]        life_max;
    logic [15:0]        size;
    logic [15:0]        red;
    logic [15:0]        green;
    logic [15:0]        blue;
  } ptcl_t;

  localparam int PTCL_W = $bits(ptcl_t);

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_SP_GEN,
    ST_SP_MA,
    ST_SP_MB,
    ST_SP_MC,
    ST_SP_DIV,
    ST_SP_WR,
    ST_TK_INIT,
    ST_TK_RD,
    ST_TK_CHK,
    ST_TK_MV,
    ST_TK_POS,
    ST_TK_VEL,
    ST_RP_RD,
    ST_RP_OUT,
    ST_STAT
  } state_t;

  typedef logic [16:0] qsin_tab_t [0:QTR];
  typedef logic [16:0] damp_tab_t [0:DAMP_N-1];

  // Quarter-wave sine in Q16 from a 9-term Taylor series in Q30
  function automatic qsin_tab_t build_qsin();
    qsin_tab_t tab;
    logic [63:0] x;
    logic [63:0] x2;
    logic [63:0] term;
    logic signed [63:0] sum;
    for (int j = 0; j <= QTR; j++) begin
      x = (64'(j) * HALF_PI_Q30) >> (ANGLE_TABLE_BITS - 2);
      x2 = (x * x) >> 30;
      term = x;
      sum = signed'(x);
      for (int k = 1; k <= 8; k++) begin
        term = ((term * x2) >> 30) / 64'((2 * k) * (2 * k + 1));
        if ((k % 2) == 1) sum = sum - signed'(term);
        else sum = sum + signed'(term);
      end
      if (sum < 0) sum = 0;
      tab[j] = 17'((64'(sum) + 64'd8192) >> 14);
    end
    return tab;
  endfunction

  // exp(-6t) in Q16: Taylor series for exp(-6t/8), squared three times
  function automatic damp_tab_t build_damp();
    damp_tab_t tab;
    logic [63:0] y;
    logic [63:0] term;
    logic signed [63:0] sum;
    logic [63:0] e;
    for (int idx = 0; idx < DAMP_N; idx++) begin
      y = ((64'(idx) << (30 - DAMP_TABLE_BITS)) * 64'd6) >> 3;
      term = 64'd1 << 30;
      sum = signed'(term);
      for (int n = 1; n <= 16; n++) begin
        term = ((term * y) >> 30) / 64'(n);
        if ((n % 2) == 1) sum = sum - signed'(term);
        else sum = sum + signed'(term);
      end
      if (sum < 0) sum = 0;
      e = 64'(sum);
      for (int n = 0; n < 3; n++) e = (e * e + (64'd1 << 29)) >> 30;
      tab[idx] = 17'((e + 64'd8192) >> 14);
    end
    return tab;
  endfunction

  localparam qsin_tab_t QSIN = build_qsin();
  localparam damp_tab_t DAMP = build_damp();

  // Full-wave sine by quadrant, Q16 signed
  function automatic logic signed [17:0] sin_at(input logic [ANGLE_TABLE_BITS-1:0] k);
    logic [1:0] quad;
    logic [ANGLE_TABLE_BITS-3:0] r;
    logic [ANGLE_TABLE_BITS-2:0] ri;
    logic [16:0] m;
    quad = k[ANGLE_TABLE_BITS-1 -: 2];
    r = k[ANGLE_TABLE_BITS-3:0];
    ri = quad[0] ? ((ANGLE_TABLE_BITS - 1)'(QTR) - {1'b0, r}) : {1'b0, r};
    m = QSIN[ri];
    return quad[1] ? -$signed({1'b0, m}) : $signed({1'b0, m});
  endfunction

  // Shift right by n, rounding to nearest with halves away from zero
  function automatic logic signed [63:0] rnd_sh(input logic signed [63:0] v,
                                                input int unsigned n);
    logic [63:0] mag;
    mag = (v < 0) ? 64'(-v) : 64'(v);
    mag = (mag + (64'd1 << (n - 1))) >> n;
    return (v < 0) ? -$signed(mag) : $signed(mag);
  endfunction

  // Clamp to 24-bit signed
  function automatic logic signed [23:0] sat24(input logic signed [63:0] v);
    if (v > 64'sd8388607) return 24'sh7FFFFF;
    if (v < -64'sd8388608) return 24'sh800000;
    return 24'(v);
  endfunction

  // xorshift32 with shifts 13, 17, 5
  function automatic logic [31:0] xs32(input logic [31:0] s);
    logic [31:0] v;
    v = s;
    v = v ^ (v << 13);
    v = v ^ (v >> 17);
    v = v ^ (v << 5);
    return v;
  endfunction

endpackage

`default_nettype wire

### sv/ppbs_ram.sv
// Generic single-port-write, single-port-read RAM with registered read data.
// No dependencies; the particle pool uses one instance.
`default_nettype none

module ppbs_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  wire logic             clk,
  input  wire logic             we,
  input  wire logic [AW-1:0]    waddr,
  input  wire logic [WIDTH-1:0] wdata,
  input  wire logic [AW-1:0]    raddr,
  output logic      [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [0:DEPTH-1];

  // Write port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // Registered read port
  always_ff @(posedge clk) begin
    rdata <= mem[raddr];
  end

endmodule

`default_nettype wire

### sv/particle_pool_burst_and_step_unit.sv
// Top level of the particle pool: handshakes, sequencer and fixed-point datapath.
// Depends on ppbs_pkg and on ppbs_ram, which holds the pool entries.
//
// Use: items enter on in_valid/in_stall, results leave on out_valid/out_stall,
// and the two registers are written through cfg_valid/cfg_ready with cfg_index
// and cfg_data. A beat moves when valid is high and stall is low.
// A spawn item (kind 0) appends up to burst_count particles and returns one
// status beat. A tick item (kind 1) ages, removes and moves every particle,
// then returns one beat per live particle in pool order, or a status beat
// when the pool is empty; the final beat of an item carries last.
// Steps per item: a spawn draws, multiplies, divides and writes once per
// particle added; a tick reads, checks and moves each survivor, or moves the
// last entry into the slot of each removal (no move when the last entry
// expires), in its update pass, then reads out each particle reported, all
// through the single read and write port of the pool RAM.
// in_stall is high while an item works.
// The result register lets the next item enter while the last beat waits;
// a stalled receiver holds the sequencer at its report step.
// Reset clears the live count, the handshakes and the registers to their
// reset values; the pool RAM needs no clearing pass.
`default_nettype none

module particle_pool_burst_and_step_unit (
  input  wire logic                                clk,
  input  wire logic                                rst,
  // input items
  input  wire logic                                in_valid,
  output logic                                     in_stall,
  input  wire logic                                kind,
  input  wire logic signed [23:0]                  spawn_x,
  input  wire logic signed [23:0]                  spawn_y,
  input  wire logic signed [23:0]                  spawn_z,
  input  wire logic [6:0]                          burst_count,
  input  wire logic [22:0]                         base_speed,
  input  wire logic [15:0]                         base_size,
  input  wire logic [15:0]                         in_red,
  input  wire logic [15:0]                         in_green,
  input  wire logic [15:0]                         in_blue,
  input  wire logic [31:0]                         seed_value,
  input  wire logic [15:0]                         time_step,
  // results
  output logic                                     out_valid,
  input  wire logic                                out_stall,
  output logic                                     has_particle,
  output logic signed [23:0]                       out_x,
  output logic signed [23:0]                       out_y,
  output logic signed [23:0]                       out_z,
  output logic [15:0]                              out_size,
  output logic [15:0]                              out_life,
  output logic [15:0]                              out_life_max,
  output logic [15:0]                              out_red,
  output logic [15:0]                              out_green,
  output logic [15:0]                              out_blue,
  output logic [6:0]                               live_total,
  output logic                                     last,
  // configuration writes
  input  wire logic                                cfg_valid,
  output logic                                     cfg_ready,
  input  wire logic [ppbs_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  wire logic [23:0]                         cfg_data
);

  localparam int CW = ppbs_pkg::CNT_W;
  localparam int AW = ppbs_pkg::ADDR_W;
  localparam int AB = ppbs_pkg::ANGLE_TABLE_BITS;
  localparam int DB = ppbs_pkg::DAMP_TABLE_BITS;

  ppbs_pkg::state_t state, state_next;

  // Registers
  logic [22:0]        gravity;
  logic signed [23:0] floor_h;

  // Pool bookkeeping
  logic [CW-1:0] cnt_live;
  logic [CW-1:0] idx;
  logic [6:0]    made;

  // Captured item
  logic signed [23:0] sx, sy, sz;
  logic [6:0]         n_req;
  logic [22:0]        speed;
  logic [15:0]        size_in;
  logic [15:0]        col_r, col_g, col_b;
  logic [31:0]        seed;
  logic [15:0]        dt;

  // Spawn datapath
  logic [2:0]          gcnt;
  logic [31:0]         xs_v;
  logic [AB-1:0]       u_ang;
  logic [23:0]         u2, u3, u5;
  logic [15:0]         life_new;
  logic signed [17:0]  cos_v, sin_v;
  logic [47:0]         spd_prod, f_prod, g_prod;
  logic [23:0]         spd;
  logic [24:0]         f_v, g_v;
  logic signed [42:0]  vxp, vyp;
  logic [40:0]         szp;
  logic [55:0]         div_num;
  logic [55:0]         div_q;
  logic [2:0]          div_rem;
  logic [2:0]          dcnt;

  // Tick datapath
  logic [16:0]         damp;
  logic [23:0]         fall;
  ppbs_pkg::ptcl_t     ent;
  ppbs_pkg::ptcl_t     rd_aged, ent_moved;
  logic signed [41:0]  pa, pb, pc;

  // RAM port
  logic              ram_we;
  logic [AW-1:0]     ram_waddr, ram_raddr;
  ppbs_pkg::ptcl_t   ram_wdata;
  logic [ppbs_pkg::PTCL_W-1:0] ram_rdata_raw;
  ppbs_pkg::ptcl_t   rd;

  logic          in_acc;
  logic          out_free;
  logic          expire;
  logic [CW-1:0] last_l;
  logic          rp_last;

  // Divider step signals
  logic [10:0] dv;
  logic [22:0] dv_prod;
  logic [7:0]  dq;

  // Tick arithmetic
  logic signed [23:0] nx, ny, nz, nvx, nvy, nvz;

  // Spawn write-back values
  logic signed [23:0] svx, svy, svz;
  logic [17:0]        sz_rnd;

  ppbs_ram #(
    .WIDTH (ppbs_pkg::PTCL_W),
    .DEPTH (ppbs_pkg::POOL_DEPTH)
  ) u_pool (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (ram_raddr),
    .rdata (ram_rdata_raw)
  );

  assign rd        = ppbs_pkg::ptcl_t'(ram_rdata_raw);
  assign cfg_ready = 1'b1;
  assign in_stall  = (state != ppbs_pkg::ST_IDLE);
  assign in_acc    = in_valid && !in_stall;
  assign out_free  = !out_valid || !out_stall;
  assign expire    = (rd.life <= dt);
  assign last_l    = cnt_live - 1'b1;
  assign rp_last   = ((idx + 1'b1) == cnt_live);

  // Next xorshift value
  assign xs_v = ppbs_pkg::xs32(seed);

  // Divide-by-five byte step
  assign dv      = {div_rem, div_num[55:48]};
  assign dv_prod = 23'(dv) * 23'(ppbs_pkg::RECIP5);
  assign dq      = dv_prod[21:14];

  // Tick position and velocity updates
  assign nx = ppbs_pkg::sat24(64'(ent.x) + ppbs_pkg::rnd_sh(64'(pa), 16));
  assign ny = ppbs_pkg::sat24(64'(ent.y) + ppbs_pkg::rnd_sh(64'(pb), 16));
  assign nz = ppbs_pkg::sat24(64'(ent.z) + ppbs_pkg::rnd_sh(64'(pc), 16));
  assign nvx = ppbs_pkg::sat24(ppbs_pkg::rnd_sh(64'(pa), 16));
  assign nvy = ppbs_pkg::sat24(ppbs_pkg::rnd_sh(64'(pb), 16));
  assign nvz = ppbs_pkg::sat24(ppbs_pkg::rnd_sh(64'(pc), 16) - $signed(64'(fall)));

  // Aged entry read from the pool, and the working entry after its move
  always_comb begin
    rd_aged        = rd;
    rd_aged.life   = rd.life - dt;
    ent_moved      = ent;
    ent_moved.x    = nx;
    ent_moved.y    = ny;
    ent_moved.z    = nz;
  end

  // Spawn velocity and size
  assign svx    = ppbs_pkg::sat24(ppbs_pkg::rnd_sh(64'(vxp), 16));
  assign svy    = ppbs_pkg::sat24(ppbs_pkg::rnd_sh(64'(vyp), 16));
  assign svz    = ppbs_pkg::sat24(ppbs_pkg::rnd_sh($signed(64'(div_q)), 24));
  assign sz_rnd = 18'((szp + 41'd8388608) >> 24);

  // Configuration writes
  always_ff @(posedge clk) begin
    if (rst) begin
      gravity <= ppbs_pkg::GRAVITY_RESET;
      floor_h <= ppbs_pkg::FLOOR_RESET;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        ppbs_pkg::REG_GRAVITY: gravity <= cfg_data[22:0];
        ppbs_pkg::REG_FLOOR:   floor_h <= $signed(cfg_data);
        default: ;
      endcase
    end
  end

  // State register
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ppbs_pkg::ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // Next state and RAM control
  always_comb begin
    state_next = state;
    ram_we     = 1'b0;
    ram_waddr  = idx[AW-1:0];
    ram_wdata  = ent;
    ram_raddr  = idx[AW-1:0];
    case (state)
      ppbs_pkg::ST_IDLE: begin
        if (in_acc) begin
          if (kind == ppbs_pkg::KIND_TICK) begin
            state_next = ppbs_pkg::ST_TK_INIT;
          end else if (burst_count == 7'd0 || 32'(cnt_live) >= ppbs_pkg::POOL_DEPTH) begin
            state_next = ppbs_pkg::ST_STAT;
          end else begin
            state_next = ppbs_pkg::ST_SP_GEN;
          end
        end
      end
      ppbs_pkg::ST_SP_GEN: begin
        if (gcnt == 3'(ppbs_pkg::GEN_DRAWS - 1)) state_next = ppbs_pkg::ST_SP_MA;
      end
      ppbs_pkg::ST_SP_MA: state_next = ppbs_pkg::ST_SP_MB;
      ppbs_pkg::ST_SP_MB: state_next = ppbs_pkg::ST_SP_MC;
      ppbs_pkg::ST_SP_MC: state_next = ppbs_pkg::ST_SP_DIV;
      ppbs_pkg::ST_SP_DIV: begin
        if (dcnt == 3'(ppbs_pkg::DIV_BYTES - 1)) state_next = ppbs_pkg::ST_SP_WR;
      end
      ppbs_pkg::ST_SP_WR: begin
        ram_we    = 1'b1;
        ram_waddr = cnt_live[AW-1:0];
        ram_wdata.x        = sx;
        ram_wdata.y        = sy;
        ram_wdata.z        = sz;
        ram_wdata.vx       = svx;
        ram_wdata.vy       = svy;
        ram_wdata.vz       = svz;
        ram_wdata.life     = life_new;
        ram_wdata.life_max = life_new;
        ram_wdata.size     = (sz_rnd > 18'd65535) ? 16'hFFFF : sz_rnd[15:0];
        ram_wdata.red      = col_r;
        ram_wdata.green    = col_g;
        ram_wdata.blue     = col_b;
        if ((made + 7'd1) < n_req && (32'(cnt_live) + 1) < ppbs_pkg::POOL_DEPTH) begin
          state_next = ppbs_pkg::ST_SP_GEN;
        end else begin
          state_next = ppbs_pkg::ST_STAT;
        end
      end
      ppbs_pkg::ST_TK_INIT: begin
        if (dt != 16'd0) state_next = ppbs_pkg::ST_TK_RD;
        else if (cnt_live == '0) state_next = ppbs_pkg::ST_STAT;
        else state_next = ppbs_pkg::ST_RP_RD;
      end
      ppbs_pkg::ST_TK_RD: begin
        if (idx >= cnt_live) begin
          state_next = (cnt_live == '0) ? ppbs_pkg::ST_STAT : ppbs_pkg::ST_RP_RD;
        end else begin
          state_next = ppbs_pkg::ST_TK_CHK;
        end
      end
      ppbs_pkg::ST_TK_CHK: begin
        if (expire) begin
          ram_raddr  = last_l[AW-1:0];
          state_next = (idx == last_l) ? ppbs_pkg::ST_TK_RD : ppbs_pkg::ST_TK_MV;
        end else begin
          state_next = ppbs_pkg::ST_TK_POS;
        end
      end
      ppbs_pkg::ST_TK_MV: begin
        // drop the expired entry: the last one takes its slot
        ram_we     = 1'b1;
        ram_wdata  = rd;
        state_next = ppbs_pkg::ST_TK_RD;
      end
      ppbs_pkg::ST_TK_POS: state_next = ppbs_pkg::ST_TK_VEL;
      ppbs_pkg::ST_TK_VEL: begin
        ram_we       = 1'b1;
        ram_wdata.vx = nvx;
        ram_wdata.vy = nvy;
        if (ent.z < floor_h) begin
          ram_wdata.z  = floor_h;
          ram_wdata.vz = '0;
        end else begin
          ram_wdata.vz = nvz;
        end
        state_next = ppbs_pkg::ST_TK_RD;
      end
      ppbs_pkg::ST_RP_RD: state_next = ppbs_pkg::ST_RP_OUT;
      ppbs_pkg::ST_RP_OUT: begin
        if (out_free) state_next = rp_last ? ppbs_pkg::ST_IDLE : ppbs_pkg::ST_RP_RD;
      end
      ppbs_pkg::ST_STAT: begin
        if (out_free) state_next = ppbs_pkg::ST_IDLE;
      end
      default: state_next = ppbs_pkg::ST_IDLE;
    endcase
  end

  // Live count and pool index
  always_ff @(posedge clk) begin
    if (rst) begin
      cnt_live <= '0;
      idx      <= '0;
    end else begin
      case (state)
        ppbs_pkg::ST_IDLE:    idx <= '0;
        ppbs_pkg::ST_SP_WR:   cnt_live <= cnt_live + 1'b1;
        ppbs_pkg::ST_TK_RD:   if (idx >= cnt_live) idx <= '0;
        ppbs_pkg::ST_TK_CHK:  if (expire) cnt_live <= last_l;
        ppbs_pkg::ST_TK_VEL:  idx <= idx + 1'b1;
        ppbs_pkg::ST_RP_OUT:  if (out_free) idx <= idx + 1'b1;
        default: ;
      endcase
    end
  end

  // Capture the item; run the spawn and tick datapaths
  always_ff @(posedge clk) begin
    case (state)
      ppbs_pkg::ST_IDLE: begin
        if (in_acc) begin
          sx      <= spawn_x;
          sy      <= spawn_y;
          sz      <= spawn_z;
          n_req   <= burst_count;
          speed   <= base_speed;
          size_in <= base_size;
          col_r   <= in_red;
          col_g   <= in_green;
          col_b   <= in_blue;
          seed    <= (seed_value == 32'd0) ? 32'd1 : seed_value;
          dt      <= time_step;
        end
        made <= '0;
        gcnt <= '0;
      end
      ppbs_pkg::ST_SP_GEN: begin
        // one xorshift draw per cycle
        seed <= xs_v;
        gcnt <= gcnt + 3'd1;
        case (gcnt)
          3'd0: u_ang <= xs_v[31 -: AB];
          3'd1: u2 <= xs_v[31:8];
          3'd2: u3 <= xs_v[31:8];
          3'd3: life_new <= ppbs_pkg::LIFE_BASE + 16'(xs_v[31:18]);
          default: u5 <= xs_v[31:8];
        endcase
      end
      ppbs_pkg::ST_SP_MA: begin
        spd_prod <= 48'(speed) * 48'({1'b0, u2} + ppbs_pkg::SPEED_ONE);
        f_prod   <= 48'(u3) * 48'(ppbs_pkg::VZ_SPAN);
        g_prod   <= 48'(u5) * 48'(ppbs_pkg::SIZE_SPAN);
        cos_v    <= ppbs_pkg::sin_at(u_ang + AB'(ppbs_pkg::QTR));
        sin_v    <= ppbs_pkg::sin_at(u_ang);
      end
      ppbs_pkg::ST_SP_MB: begin
        spd <= 24'((spd_prod + 48'd8388608) >> 24);
        f_v <= ppbs_pkg::VZ_MIN_F + 25'(f_prod[47:24]);
        g_v <= ppbs_pkg::SIZE_MIN_G + 25'(g_prod[47:24]);
      end
      ppbs_pkg::ST_SP_MC: begin
        vxp     <= 43'(cos_v) * 43'($signed({1'b0, spd}));
        vyp     <= 43'(sin_v) * 43'($signed({1'b0, spd}));
        szp     <= 41'(size_in) * 41'(g_v);
        div_num <= 56'({48'(speed) * 48'(f_v), 2'b00});
        div_q   <= '0;
        div_rem <= '0;
        dcnt    <= '0;
      end
      ppbs_pkg::ST_SP_DIV: begin
        // long division by five, one byte per cycle
        div_q   <= {div_q[47:0], dq};
        div_rem <= 3'(dv - 11'(dq) * 11'(ppbs_pkg::DIV_FIVE));
        div_num <= {div_num[47:0], 8'd0};
        dcnt    <= dcnt + 3'd1;
      end
      ppbs_pkg::ST_SP_WR: begin
        made <= made + 7'd1;
        gcnt <= '0;
      end
      ppbs_pkg::ST_TK_INIT: begin
        damp <= ppbs_pkg::DAMP[dt[15 -: DB]];
        fall <= 24'((40'(gravity) * 40'(dt) + 40'd32768) >> 16);
      end
      ppbs_pkg::ST_TK_CHK: begin
        ent <= rd_aged;
        pa <= 42'(rd.vx) * 42'($signed({1'b0, dt}));
        pb <= 42'(rd.vy) * 42'($signed({1'b0, dt}));
        pc <= 42'(rd.vz) * 42'($signed({1'b0, dt}));
      end
      ppbs_pkg::ST_TK_POS: begin
        ent <= ent_moved;
        pa <= 42'(ent.vx) * 42'($signed({1'b0, damp}));
        pb <= 42'(ent.vy) * 42'($signed({1'b0, damp}));
        pc <= 42'(ent.vz) * 42'($signed({1'b0, damp}));
      end
      default: ;
    endcase
  end

  // Result register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (state == ppbs_pkg::ST_STAT && out_free) begin
      out_valid <= 1'b1;
    end else if (state == ppbs_pkg::ST_RP_OUT && out_free) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  // Result payload: status beat or one pool entry
  always_ff @(posedge clk) begin
    if (state == ppbs_pkg::ST_STAT && out_free) begin
      has_particle <= 1'b0;
      out_x        <= '0;
      out_y        <= '0;
      out_z        <= '0;
      out_size     <= '0;
      out_life     <= '0;
      out_life_max <= '0;
      out_red      <= '0;
      out_green    <= '0;
      out_blue     <= '0;
      live_total   <= 7'(cnt_live);
      last         <= 1'b1;
    end else if (state == ppbs_pkg::ST_RP_OUT && out_free) begin
      has_particle <= 1'b1;
      out_x        <= rd.x;
      out_y        <= rd.y;
      out_z        <= rd.z;
      out_size     <= rd.size;
      out_life     <= rd.life;
      out_life_max <= rd.life_max;
      out_red      <= rd.red;
      out_green    <= rd.green;
      out_blue     <= rd.blue;
      live_total   <= 7'(cnt_live);
      last         <= rp_last;
    end
  end

endmodule

`default_nettype wire
